FILE: rtl/core/mkdb_pkg.sv
package mkdb_pkg;

   localparam logic       CMD_PIN       = 1'b0;
   localparam logic       CMD_TICK      = 1'b1;

   localparam logic [1:0] PH_IDLE       = 2'd0;
   localparam logic [1:0] PH_DEBOUNCE   = 2'd1;
   localparam logic [1:0] PH_PRESSED    = 2'd2;

   localparam logic       EV_PRESS      = 1'b0;
   localparam logic       EV_RELEASE    = 1'b1;

   localparam logic [1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [1:0] CSR_PRESS_HI  = 2'd1;
   localparam logic [1:0] CSR_KEY_EN    = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [7:0]  PRESS_HI_RESET = 8'h00;
   localparam logic [7:0]  KEY_EN_RESET   = 8'hFF;

   typedef struct packed {
      logic       cmd;
      logic [2:0] key_index;
      logic       level;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] key_id;
      logic       key_event;
      logic       last;
   } rsp_payload_type;

endpackage

FILE: rtl/core/multi_key_debounce_fsm_core.sv
// Debounces up to NUM_KEYS keys whose state (phase, countdown, last pin level) lives in one
// synchronous RAM with one entry per key. A pin change request first reads the key's entry,
// then updates it and reports a release if needed. A tick request walks the RAM one key per
// cycle, except while the response side holds off a press report. Press reports of a tick
// come in key order, and the last response caused by a request carries last = 1. A new
// request is taken as soon as the previous one is done, even while its final response still
// waits in the output register. Entries need no clearing pass after reset: a per-key valid
// bit makes an unwritten entry read as idle.
module multi_key_debounce_fsm_core
   import mkdb_pkg::*;
#(
   parameter int NUM_KEYS   = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata
);

   localparam int KEY_BITS = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int ENTRY_W  = COUNT_BITS + 3;
   localparam logic [KEY_BITS-1:0] LAST_KEY = KEY_BITS'(NUM_KEYS - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PIN   = 4'b0010,
      S_SWEEP = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   function automatic logic mask_bit(input logic [7:0] m, input logic [31:0] k);
      logic r;
      r = 1'b0;
      if (k < 32'd8) begin
         r = m[k[2:0]];
      end
      return r;
   endfunction

   state_type             state_ff, state_in;
   logic [KEY_BITS-1:0]   idx_ff, idx_in;
   logic                  lvl_ff, lvl_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [2:0]            pend_key_ff, pend_key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;
   logic [15:0]           debounce_ticks_ff;
   logic [7:0]            press_high_ff;
   logic [7:0]            key_enable_ff;

   logic [ENTRY_W-1:0]    key_mem_ff [NUM_KEYS];
   logic [NUM_KEYS-1:0]   entry_valid_ff;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  rd_valid_ff;

   logic                  rd_en, wr_en;
   logic [KEY_BITS-1:0]   rd_addr;
   logic [ENTRY_W-1:0]    wr_data;

   logic [ENTRY_W-1:0]    cur_entry;
   logic [1:0]            cur_phase;
   logic [COUNT_BITS-1:0] cur_left;
   logic                  cur_pin;
   logic [COUNT_BITS-1:0] load_val;
   logic                  slot_free;
   logic [31:0]           req_key32;
   logic [31:0]           idx32;
   logic                  req_key_ok;

   logic [1:0]            pin_phase;
   logic [COUNT_BITS-1:0] pin_left;
   logic                  pin_emit;
   logic [1:0]            tick_phase;
   logic [COUNT_BITS-1:0] tick_left;
   logic                  tick_emit;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cur_entry = rd_valid_ff ? rd_data_ff : '0;
   assign cur_phase = cur_entry[ENTRY_W-1 -: 2];
   assign cur_left  = cur_entry[COUNT_BITS:1];
   assign cur_pin   = cur_entry[0];

   assign req_key32  = 32'(req_data.key_index);
   assign idx32      = 32'(idx_ff);
   assign req_key_ok = (req_key32 < NUM_KEYS) && mask_bit(key_enable_ff, req_key32);

   always_comb begin
      load_val = COUNT_BITS'(debounce_ticks_ff);
      if (load_val == '0) begin
         load_val = COUNT_BITS'(1);
      end
   end

   always_comb begin
      pin_phase = cur_phase;
      pin_left  = cur_left;
      pin_emit  = 1'b0;
      case (cur_phase)
         PH_IDLE: begin
            if (lvl_ff == mask_bit(press_high_ff, idx32)) begin
               pin_phase = PH_DEBOUNCE;
               pin_left  = load_val;
            end else begin
               pin_emit = 1'b1;
            end
         end
         PH_DEBOUNCE: begin
            pin_phase = PH_DEBOUNCE;
         end
         PH_PRESSED: begin
            pin_phase = PH_IDLE;
            pin_emit  = 1'b1;
         end
         default: begin
            pin_phase = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      tick_phase = cur_phase;
      tick_left  = cur_left;
      tick_emit  = 1'b0;
      if (cur_phase == PH_DEBOUNCE) begin
         if (cur_left > COUNT_BITS'(1)) begin
            tick_left = cur_left - COUNT_BITS'(1);
         end else begin
            tick_left = '0;
            if (cur_pin == mask_bit(press_high_ff, idx32)) begin
               tick_phase = PH_PRESSED;
               tick_emit  = 1'b1;
            end else begin
               tick_phase = PH_IDLE;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_data       = cur_entry;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == CMD_TICK) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = S_SWEEP;
               end else if (req_key_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = req_key32[KEY_BITS-1:0];
                  idx_in   = req_key32[KEY_BITS-1:0];
                  lvl_in   = req_data.level;
                  state_in = S_PIN;
               end
            end
         end
         S_PIN: begin
            if (!pin_emit || slot_free) begin
               wr_en   = 1'b1;
               wr_data = {pin_phase, pin_left, lvl_ff};
               if (pin_emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{key_id: idx32[2:0], key_event: EV_RELEASE, last: 1'b1};
               end
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            if (!(tick_emit && pend_valid_ff && !slot_free)) begin
               wr_en   = 1'b1;
               wr_data = {tick_phase, tick_left, cur_pin};
               if (tick_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{key_id: pend_key_ff, key_event: EV_PRESS, last: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_key_in   = idx32[2:0];
               end
               if (idx_ff == LAST_KEY) begin
                  state_in = S_FLUSH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + KEY_BITS'(1);
                  idx_in  = idx_ff + KEY_BITS'(1);
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '{key_id: pend_key_ff, key_event: EV_PRESS, last: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= key_mem_ff[rd_addr];
         rd_valid_ff <= entry_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         pend_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         entry_valid_ff    <= '0;
         debounce_ticks_ff <= DEBOUNCE_RESET;
         press_high_ff     <= PRESS_HI_RESET;
         key_enable_ff     <= KEY_EN_RESET;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_en) begin
            entry_valid_ff[idx_ff] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEBOUNCE: debounce_ticks_ff <= csr_wdata;
               CSR_PRESS_HI: press_high_ff     <= csr_wdata[7:0];
               CSR_KEY_EN:   key_enable_ff     <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lvl_ff      <= lvl_in;
      pend_key_ff <= pend_key_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/core/mkdb_checker.sv
module mkdb_checker
   import mkdb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A release is only ever the single response of a pin change request.
   a_release_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.key_event == EV_RELEASE |-> rsp_data.last)
      else $error("release response without last");

   // A tick request walks the key memory, so the block is busy in the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd == CMD_TICK |=> !req_ready)
      else $error("ready right after a tick request");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind multi_key_debounce_fsm_core mkdb_checker u_mkdb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
